// ----- hw/rtl/rte_pkg.sv -----
// ----------------------------------------------------------------------------
// rte_pkg
// Shared types, constants and tables for the rotation transform engine.
// ----------------------------------------------------------------------------
package rte_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_STEPS_MAX = 24;

    localparam int MAT_W   = 18;
    localparam int COORD_W = 32;
    localparam int ANGLE_W = 16;
    localparam int OP_W    = 3;
    localparam int CX_W    = 34;  // CORDIC x/y, Q2.30 plus growth
    localparam int CZ_W    = 32;  // CORDIC residual angle

    localparam logic signed [MAT_W-1:0] ONE_Q16 = 18'sd65536;
    localparam logic signed [CX_W-1:0]  CORDIC_K = 34'sd652032874;

    typedef enum logic [OP_W-1:0] {
        OP_IDENT = 3'd0,
        OP_ROT_X = 3'd1,
        OP_ROT_Y = 3'd2,
        OP_ROT_Z = 3'd3,
        OP_XFORM = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CORDIC,
        S_MAC,
        S_WRITE,
        S_OUT
    } t_state;

    // Handshake from the top level sequencer to the CORDIC unit.
    typedef struct packed {
        logic start;
    } t_cordic_ctl;

    typedef struct packed {
        logic done;
    } t_cordic_sts;

    function automatic logic signed [CZ_W-1:0] atan_lut(input logic [4:0] idx);
        logic signed [CZ_W-1:0] v;
        unique case (idx)
            5'd0:  v = 32'sh20000000;
            5'd1:  v = 32'sh12E4051E;
            5'd2:  v = 32'sh09FB385B;
            5'd3:  v = 32'sh051111D4;
            5'd4:  v = 32'sh028B0D43;
            5'd5:  v = 32'sh0145D7E1;
            5'd6:  v = 32'sh00A2F61E;
            5'd7:  v = 32'sh00517C55;
            5'd8:  v = 32'sh0028BE53;
            5'd9:  v = 32'sh00145F2F;
            5'd10: v = 32'sh000A2F98;
            5'd11: v = 32'sh000517CC;
            5'd12: v = 32'sh00028BE6;
            5'd13: v = 32'sh000145F3;
            5'd14: v = 32'sh0000A2F9;
            5'd15: v = 32'sh0000517D;
            5'd16: v = 32'sh000028BE;
            5'd17: v = 32'sh0000145F;
            5'd18: v = 32'sh00000A30;
            5'd19: v = 32'sh00000518;
            5'd20: v = 32'sh0000028C;
            5'd21: v = 32'sh00000146;
            5'd22: v = 32'sh000000A3;
            5'd23: v = 32'sh00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/rte_cordic.sv -----
// ----------------------------------------------------------------------------
// rte_cordic
// Iterative CORDIC, one rotation step per cycle, gives sine and cosine in Q1.16.
// ----------------------------------------------------------------------------
module rte_cordic #(
    parameter int CORDIC_STEPS = rte_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rte_pkg::t_cordic_ctl                i_ctl,
    input  logic [rte_pkg::ANGLE_W-1:0]         i_angle,
    output rte_pkg::t_cordic_sts                o_sts,
    output logic signed [rte_pkg::MAT_W-1:0]    o_sin,
    output logic signed [rte_pkg::MAT_W-1:0]    o_cos
);
    import rte_pkg::*;

    localparam int CW = $clog2(CORDIC_STEPS + 1);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic signed [CX_W-1:0] r_x, n_x, r_y, n_y;
    logic signed [CZ_W-1:0] r_z, n_z;
    logic [1:0]             r_q;
    logic signed [CX_W-1:0] w_dx, w_dy;
    logic signed [CX_W-1:0] w_xr, w_yr;
    logic signed [19:0]     w_c, w_s;
    logic signed [MAT_W-1:0] w_cc, w_sc;

    assign w_dx = r_y >>> r_cnt;
    assign w_dy = r_x >>> r_cnt;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_done = 1'b0;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_x    = CORDIC_K;
            n_y    = '0;
            n_z    = CZ_W'({i_angle[13:0], 16'h0000});
        end else if (r_busy) begin
            if (r_z >= 0) begin
                n_x = r_x - w_dx;
                n_y = r_y + w_dy;
                n_z = r_z - atan_lut(5'(r_cnt));
            end else begin
                n_x = r_x + w_dx;
                n_y = r_y - w_dy;
                n_z = r_z + atan_lut(5'(r_cnt));
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(CORDIC_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
        if (i_ctl.start) r_q <= i_angle[15:14];
    end

    // round half up by 2^14, clamp to +-1.0
    assign w_xr = (r_x + CX_W'(34'sd8192)) >>> 14;
    assign w_yr = (r_y + CX_W'(34'sd8192)) >>> 14;
    assign w_c  = (w_xr > 65536) ? 20'sd65536 : (w_xr < -65536) ? -20'sd65536 : w_xr[19:0];
    assign w_s  = (w_yr > 65536) ? 20'sd65536 : (w_yr < -65536) ? -20'sd65536 : w_yr[19:0];
    assign w_cc = w_c[MAT_W-1:0];
    assign w_sc = w_s[MAT_W-1:0];

    always_comb begin
        unique case (r_q)
            2'd0: begin o_cos = w_cc;  o_sin = w_sc;  end
            2'd1: begin o_cos = -w_sc; o_sin = w_cc;  end
            2'd2: begin o_cos = -w_cc; o_sin = -w_sc; end
            default: begin o_cos = w_sc; o_sin = -w_cc; end
        endcase
    end

    // high for one cycle once the last step has landed in r_x/r_y
    assign o_sts.done = r_done;

endmodule

// ----- hw/rtl/rotation_transform_engine.sv -----
// ----------------------------------------------------------------------------
// rotation_transform_engine
// Composes 3x3 rotations and transforms points with one shared MAC.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis carries one command word: opcode, angle, x, y, z.
//   Master stream m_axis carries one result word per transform (opcode 4):
//   x_out, y_out, z_out and the saturated flag in tuser.
//   Opcode 0 loads identity. Opcodes 1..3 run the CORDIC, latch sin/cos
//   into a rotation matrix, then do 27 serial multiply-accumulates (one per
//   cycle, three per matrix entry) and a writeback of the new matrix; the
//   next word is taken once the engine is back in idle. Opcode 4 does 9
//   multiply-accumulates, then sets the output valid in its output state.
//   Opcodes 5..7 are dropped.
//   The single 18x33 multiplier sets the rate; one word is in flight at a time
//   and s_axis_tready is low while it is processed.
//   Reset (i_rst_n low, synchronous) loads identity and empties the output.
//   If the receiver stalls, the result word holds in the output register and
//   no new command is taken until it is accepted.
// ----------------------------------------------------------------------------
module rotation_transform_engine #(
    parameter int CORDIC_STEPS = rte_pkg::CORDIC_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [2:0] opcode, [18:3] angle, [50:19] x_in, [82:51] y_in, [114:83] z_in
    input  logic [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] x_out, [63:32] y_out, [95:64] z_out
    output logic [95:0]  m_axis_tdata,
    // [0] saturated
    output logic         m_axis_tuser
);
    import rte_pkg::*;

    t_state r_state, n_state;
    logic signed [MAT_W-1:0] r_mat [9];
    logic signed [MAT_W-1:0] r_nm  [9];
    logic signed [MAT_W-1:0] r_r   [9];
    logic [OP_W-1:0]         r_op;
    logic signed [COORD_W-1:0] r_p [3];
    logic [3:0]   r_ent;      // result entry 0..8
    logic [1:0]   r_k;        // term 0..2
    logic signed [53:0] r_acc;
    logic signed [COORD_W-1:0] r_out [3];
    logic         r_sat;
    logic         r_ovalid;

    t_cordic_ctl  w_cctl;
    t_cordic_sts  w_csts;
    logic signed [MAT_W-1:0] w_sin, w_cos;

    logic         w_take;
    logic [1:0]   w_i, w_j;
    logic signed [MAT_W-1:0]  w_a;
    logic signed [COORD_W:0]  w_b;
    logic signed [53:0] w_prod, w_sum, w_rnd;
    logic signed [MAT_W-1:0]  w_mres;
    logic signed [COORD_W-1:0] w_pres;
    logic         w_psat;
    logic         w_last;

    rte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_cctl),
        .i_angle(s_axis_tdata[18:3]),
        .o_sts  (w_csts),
        .o_sin  (w_sin),
        .o_cos  (w_cos)
    );

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign w_take = s_axis_tvalid && s_axis_tready;
    assign w_cctl.start = w_take && (s_axis_tdata[2:0] == OP_ROT_X ||
                          s_axis_tdata[2:0] == OP_ROT_Y || s_axis_tdata[2:0] == OP_ROT_Z);

    // entry index -> row/col
    always_comb begin
        unique case (r_ent)
            4'd0, 4'd1, 4'd2: w_i = 2'd0;
            4'd3, 4'd4, 4'd5: w_i = 2'd1;
            default:          w_i = 2'd2;
        endcase
        unique case (r_ent)
            4'd0, 4'd3, 4'd6: w_j = 2'd0;
            4'd1, 4'd4, 4'd7: w_j = 2'd1;
            default:          w_j = 2'd2;
        endcase
    end

    // operand select: matrix update uses R[i][k]*M[k][j], transform M[i][k]*p[k]
    // (a transform walks only three entries, so the entry index is the row)
    always_comb begin
        if (r_op == OP_XFORM) begin
            w_a = r_mat[4'(r_ent[1:0]) * 4'd3 + 4'(r_k)];
            w_b = (COORD_W+1)'(r_p[r_k]);
        end else begin
            w_a = r_r[4'(w_i) * 4'd3 + 4'(r_k)];
            w_b = (COORD_W+1)'(r_mat[4'(r_k) * 4'd3 + 4'(w_j)]);
        end
    end

    assign w_prod = 54'(w_a * w_b);
    assign w_sum  = r_acc + w_prod;
    assign w_rnd  = (w_sum + 54'sd32768) >>> 16;
    assign w_mres = (w_rnd > 54'sd131071) ? 18'sd131071 :
                    (w_rnd < -54'sd131072) ? -18'sd131072 : w_rnd[MAT_W-1:0];
    assign w_psat = (w_rnd > 54'sd2147483647) || (w_rnd < -54'sd2147483648);
    assign w_pres = (w_rnd > 54'sd2147483647) ? 32'sh7FFFFFFF :
                    (w_rnd < -54'sd2147483648) ? 32'sh80000000 : w_rnd[COORD_W-1:0];
    assign w_last = (r_k == 2'd2) &&
                    (r_ent == ((r_op == OP_XFORM) ? 4'd2 : 4'd8));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    if (w_cctl.start) n_state = S_CORDIC;
                    else if (s_axis_tdata[2:0] == OP_XFORM) n_state = S_MAC;
                end
            end
            S_CORDIC: if (w_csts.done) n_state = S_MAC;
            S_MAC:    if (w_last) n_state = (r_op == OP_XFORM) ? S_OUT : S_WRITE;
            S_WRITE:  n_state = S_IDLE;
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int e = 0; e < 9; e++) r_mat[e] <= (e % 4 == 0) ? ONE_Q16 : '0;
        end else begin
            r_state <= n_state;
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            if (r_state == S_OUT) r_ovalid <= 1'b1;
            if (w_take && s_axis_tdata[2:0] == OP_IDENT)
                for (int e = 0; e < 9; e++) r_mat[e] <= (e % 4 == 0) ? ONE_Q16 : '0;
            if (r_state == S_WRITE)
                for (int e = 0; e < 9; e++) r_mat[e] <= r_nm[e];
        end
        if (w_take) begin
            r_op   <= s_axis_tdata[2:0];
            r_p[0] <= s_axis_tdata[50:19];
            r_p[1] <= s_axis_tdata[82:51];
            r_p[2] <= s_axis_tdata[114:83];
            r_ent  <= '0;
            r_k    <= '0;
            r_acc  <= '0;
            r_sat  <= 1'b0;
        end
        if (r_state == S_CORDIC && w_csts.done) begin
            for (int e = 0; e < 9; e++) r_r[e] <= '0;
            unique case (r_op)
                OP_ROT_X: begin
                    r_r[0] <= ONE_Q16; r_r[4] <= w_cos; r_r[5] <= -w_sin;
                    r_r[7] <= w_sin;   r_r[8] <= w_cos;
                end
                OP_ROT_Y: begin
                    r_r[0] <= w_cos; r_r[2] <= -w_sin; r_r[4] <= ONE_Q16;
                    r_r[6] <= w_sin; r_r[8] <= w_cos;
                end
                default: begin
                    r_r[0] <= w_cos; r_r[1] <= -w_sin; r_r[3] <= w_sin;
                    r_r[4] <= w_cos; r_r[8] <= ONE_Q16;
                end
            endcase
        end
        if (r_state == S_MAC) begin
            if (r_k == 2'd2) begin
                r_acc <= '0;
                r_k   <= '0;
                r_ent <= r_ent + 4'd1;
                if (r_op == OP_XFORM) begin
                    r_out[r_ent[1:0]] <= w_pres;
                    if (w_psat) r_sat <= 1'b1;
                end else begin
                    r_nm[r_ent] <= w_mres;
                end
            end else begin
                r_acc <= w_sum;
                r_k   <= r_k + 2'd1;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_out[2], r_out[1], r_out[0]};
    assign m_axis_tuser  = r_sat;

endmodule

// ----- sim/rotation_transform_engine_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_transform_engine_tb
// Self-checking bench: composes random rotations, transforms points and
// compares each transformed point against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------

class xform_scoreboard;
    logic signed [31:0] mtx [9];
    logic [96:0] pending [$];
    int errors;
    int checked;

    function new();
        errors = 0;
        checked = 0;
        load_identity();
    endfunction

    function void load_identity();
        for (int i = 0; i < 9; i++) mtx[i] = (i % 4 == 0) ? 32'sd65536 : 32'sd0;
    endfunction

    static function longint asr(longint v, int s);
        return v >>> s;
    endfunction

    static function longint rnd_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    static function longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // fixed CORDIC with quadrant folding, 16 iterations
    static function void sin_cos(logic [15:0] ang, output longint s, output longint c);
        longint x, y, z, dx, dy, cc, ss;
        logic [1:0] quad;
        quad = ang[15:14];
        z = longint'(ang[13:0]) << 16;
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(rte_pkg::atan_lut(i[4:0]));
            end else begin
                x += dx; y -= dy; z += longint'(rte_pkg::atan_lut(i[4:0]));
            end
        end
        cc = clip(rnd_shift(x, 14), -65536, 65536);
        ss = clip(rnd_shift(y, 14), -65536, 65536);
        case (quad)
            2'd0: begin c = cc;  s = ss;  end
            2'd1: begin c = -ss; s = cc;  end
            2'd2: begin c = -cc; s = -ss; end
            default: begin c = ss; s = -cc; end
        endcase
    endfunction

    // notes one accepted command word
    function void note_command(rte_pkg::t_opcode op, logic [15:0] ang,
                               logic signed [31:0] px, logic signed [31:0] py,
                               logic signed [31:0] pz);
        longint r [9];
        longint nm [9];
        longint s, c, acc, v, cv, p [3];
        logic [95:0] res;
        logic sat;
        case (op)
            rte_pkg::OP_IDENT: load_identity();
            rte_pkg::OP_ROT_X, rte_pkg::OP_ROT_Y, rte_pkg::OP_ROT_Z: begin
                sin_cos(ang, s, c);
                for (int i = 0; i < 9; i++) r[i] = 0;
                if (op == rte_pkg::OP_ROT_X) begin
                    r[0] = 65536; r[4] = c; r[5] = -s; r[7] = s; r[8] = c;
                end else if (op == rte_pkg::OP_ROT_Y) begin
                    r[0] = c; r[2] = -s; r[4] = 65536; r[6] = s; r[8] = c;
                end else begin
                    r[0] = c; r[1] = -s; r[3] = s; r[4] = c; r[8] = 65536;
                end
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++) begin
                        acc = 0;
                        for (int k = 0; k < 3; k++) acc += r[i*3+k] * longint'(mtx[k*3+j]);
                        nm[i*3+j] = clip(rnd_shift(acc, 16), -131072, 131071);
                    end
                for (int i = 0; i < 9; i++) mtx[i] = 32'(nm[i]);
            end
            rte_pkg::OP_XFORM: begin
                p[0] = px; p[1] = py; p[2] = pz;
                sat = 1'b0;
                for (int i = 0; i < 3; i++) begin
                    acc = 0;
                    for (int k = 0; k < 3; k++) acc += longint'(mtx[i*3+k]) * p[k];
                    v = rnd_shift(acc, 16);
                    cv = clip(v, -64'sd2147483648, 64'sd2147483647);
                    if (cv != v) sat = 1'b1;
                    res[i*32 +: 32] = cv[31:0];
                end
                pending.push_back({sat, res});
            end
            default: ;  // unused opcodes are dropped
        endcase
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    task check_point(logic [95:0] data, logic sat);
        logic [96:0] want;
        if (pending.size() == 0) begin
            report("unexpected word", data[31:0], 32'h0);
            return;
        end
        want = pending.pop_front();
        checked++;
        if (data[31:0] !== want[31:0]) report("x_out", data[31:0], want[31:0]);
        if (data[63:32] !== want[63:32]) report("y_out", data[63:32], want[63:32]);
        if (data[95:64] !== want[95:64]) report("z_out", data[95:64], want[95:64]);
        if (sat !== want[96]) report("saturated", {31'b0, sat}, {31'b0, want[96]});
    endtask
endclass

module rotation_transform_engine_tb;
    import rte_pkg::*;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata;   // opcode, angle, x_in, y_in, z_in
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;   // x_out, y_out, z_out
    logic         m_axis_tuser;   // saturated

    xform_scoreboard sb;
    bit  idle_off;
    bit  hold_long;
    bit  sending_done;
    int  sent;

    rotation_transform_engine dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("rotation_transform_engine verification failed");
        $finish;
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 600000))
                                           : -32'($urandom_range(0, 600000));
            default: return $urandom;
        endcase
    endfunction

    // sends one command word, with optional random gap before it
    task automatic send_word(logic [2:0] op, logic [15:0] ang,
                             logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        if (!idle_off && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, pz, py, px, ang, op};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_command(t_opcode'(op), ang, px, py, pz);
        sent++;
    endtask

    task automatic send_random();
        int r;
        logic [2:0] op;
        r = $urandom_range(0, 99);
        if (r < 3) op = 3'($urandom_range(5, 7));
        else if (r < 8) op = OP_IDENT;
        else if (r < 45) op = 3'($urandom_range(1, 3));
        else op = OP_XFORM;
        send_word(op, 16'($urandom), pick_coord(), pick_coord(), pick_coord());
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_long) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_long = 1'b0;
            end else if (!idle_off && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) sb.check_point(m_axis_tdata, m_axis_tuser);
        end
    end

    initial begin
        int wait_cnt;
        sb = new();
        idle_off = 1'b0;
        hold_long = 1'b0;
        sent = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every opcode, unused opcodes
        send_word(OP_XFORM, 16'h0, 32'h7FFFFFFF, 32'h80000000, 32'h00010000);
        send_word(OP_ROT_X, 16'h0000, 0, 0, 0);
        send_word(OP_ROT_Y, 16'h4000, 0, 0, 0);
        send_word(OP_ROT_Z, 16'hFFFF, 0, 0, 0);
        send_word(OP_XFORM, 16'hFFFF, 32'h00010000, 32'hFFFF0000, 32'h7FFFFFFF);
        send_word(3'd5, 16'h1234, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_word(3'd6, 16'h8000, 0, 0, 0);
        send_word(3'd7, 16'hC000, 0, 0, 0);
        send_word(OP_XFORM, 16'h0, 32'h80000000, 32'h80000000, 32'h80000000);
        send_word(OP_ROT_Z, 16'h2000, 0, 0, 0);
        send_word(OP_ROT_X, 16'h8000, 0, 0, 0);
        send_word(OP_ROT_Y, 16'hC000, 0, 0, 0);
        send_word(OP_XFORM, 16'h0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_word(OP_IDENT, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_word(OP_XFORM, 16'h0, 32'h12345678, 32'hEDCBA987, 32'h00000000);

        // random body; long receiver hold-off early on
        for (int n = 0; n < 1650; n++) begin
            if (n == 100) hold_long = 1'b1;
            if (n == 1450) idle_off = 1'b1;
            send_random();
        end
        s_axis_tvalid <= 1'b0;

        wait_cnt = 0;
        while (sb.pending.size() != 0 && wait_cnt < 100000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (100) @(posedge i_clk);
        $display("Sent %0d command words; %0d transformed points checked, %0d mismatches.",
                 sent, sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("rotation_transform_engine verification clean");
        else
            $display("rotation_transform_engine verification failed");
        $finish;
    end
endmodule
